@@ rtl/sok_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sok_pkg
// Shared widths, codes and controller/datapath handshake types for the
// spiral order lookup block.
// ----------------------------------------------------------------------------
package sok_pkg;

  localparam int MAX_DIM_DEF = 64;
  localparam int DATA_W      = 32;
  localparam int POS_W       = 16;
  localparam int COORD_W     = 6;
  localparam int SIZE_W      = 7;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    SIDE_TOP,
    SIDE_RIGHT,
    SIDE_BOTTOM,
    SIDE_LEFT
  } side_e;

  typedef struct packed {
    logic wr_en;
    logic start;
    logic step;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/sok_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sok_req_if / sok_rsp_if
// Valid/ready channels carrying a request into the block and a result out.
// ----------------------------------------------------------------------------
interface sok_req_if;
  logic                                valid;
  logic                                ready;
  sok_pkg::op_e                        opcode;
  logic        [sok_pkg::COORD_W-1:0]  row;
  logic        [sok_pkg::COORD_W-1:0]  col;
  logic signed [sok_pkg::DATA_W-1:0]   value;
  logic        [sok_pkg::POS_W-1:0]    position;

  modport source (output valid, opcode, row, col, value, position, input ready);
  modport sink   (input valid, opcode, row, col, value, position, output ready);
endinterface

interface sok_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic signed [sok_pkg::DATA_W-1:0] element;

  modport source (output valid, found, element, input ready);
  modport sink   (input valid, found, element, output ready);
endinterface

@@ rtl/spiral_order_kth_element_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spiral_order_kth_element_core
// Stores a matrix of signed 32-bit entries and returns the entry at a given
// 1-based position of its clockwise spiral walk.
//
// req_i carries write and query requests, rsp_o one result per query; both
// are valid/ready channels. The APB port holds rows (0x0) and cols (0x4).
// A write request is taken and gives no result. A query first loads the
// spiral bounds and its position, then visits one spiral side per step,
// at most 4*ceil(min(rows,cols)/2)+1 steps (129 for a full 64x64 matrix),
// and then moves the result into the output register once it is free.
// A new request is taken once the result is registered, even while the
// receiver stalls; a further result waits until the register frees.
// Reset clears the size registers to 1 and empties the output register; matrix
// memory is not cleared; user must read entries only after written (unchecked).
// ----------------------------------------------------------------------------
module spiral_order_kth_element_core #(
  parameter int MAX_DIM = sok_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sok_req_if.sink                       req_i,
  sok_rsp_if.source                     rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sok_pkg::APB_AW-1:0]    paddr,
  input  logic [sok_pkg::APB_DW-1:0]    pwdata,
  output logic [sok_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  logic [sok_pkg::SIZE_W-1:0] rows_q, rows_d, cols_q, cols_d;
  logic [DIM_W-1:0]           n_rows, n_cols;
  logic                       cfg_wr;
  sok_pkg::reg_e              cfg_reg;
  sok_pkg::dp_cmd_t           cmd;
  sok_pkg::dp_status_t        status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_reg = sok_pkg::reg_e'(paddr[2]);

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_wr) begin
      unique case (cfg_reg)
        sok_pkg::REG_ROWS: rows_d = pwdata[sok_pkg::SIZE_W-1:0];
        sok_pkg::REG_COLS: cols_d = pwdata[sok_pkg::SIZE_W-1:0];
        default: rows_d = rows_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      sok_pkg::REG_ROWS: prdata = sok_pkg::APB_DW'(rows_q);
      sok_pkg::REG_COLS: prdata = sok_pkg::APB_DW'(cols_q);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= sok_pkg::SIZE_W'(1);
      cols_q <= sok_pkg::SIZE_W'(1);
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
    end
  end

  // size saturates to the store
  assign n_rows = (32'(rows_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(rows_q);
  assign n_cols = (32'(cols_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cols_q);

  sok_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_opcode_i (req_i.opcode),
    .req_ready_o  (req_i.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  sok_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .n_rows_i      (n_rows),
    .n_cols_i      (n_cols),
    .wr_row_i      (req_i.row),
    .wr_col_i      (req_i.col),
    .wr_value_i    (req_i.value),
    .position_i    (req_i.position),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_found_o   (rsp_o.found),
    .rsp_element_o (rsp_o.element)
  );

endmodule

@@ rtl/sok_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sok_ctrl
// Controller: takes requests, steps the spiral walk and hands the result to
// the output register.
// ----------------------------------------------------------------------------
module sok_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  sok_pkg::op_e        req_opcode_i,
  output logic                req_ready_o,
  input  sok_pkg::dp_status_t status_i,
  output sok_pkg::dp_cmd_t    cmd_o
);

  sok_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sok_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sok_pkg::ST_IDLE: begin
        if (req_valid_i && (req_opcode_i == sok_pkg::OP_QUERY)) begin
          state_d = sok_pkg::ST_WALK;
        end
      end
      sok_pkg::ST_WALK: begin
        if (status_i.hit || status_i.miss) begin
          state_d = sok_pkg::ST_DONE;
        end
      end
      sok_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          state_d = sok_pkg::ST_IDLE;
        end
      end
      default: state_d = sok_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      sok_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.wr_en = req_valid_i && (req_opcode_i == sok_pkg::OP_WRITE);
        cmd_o.start = req_valid_i && (req_opcode_i == sok_pkg::OP_QUERY);
      end
      sok_pkg::ST_WALK: begin
        cmd_o.step = 1'b1;
      end
      sok_pkg::ST_DONE: begin
        cmd_o.load = status_i.out_free;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/sok_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sok_dp
// Datapath: matrix memory, spiral bounds with the remaining count, and the
// result register.
// ----------------------------------------------------------------------------
module sok_dp #(
  parameter int MAX_DIM = sok_pkg::MAX_DIM_DEF,
  localparam int DIM_W  = $clog2(MAX_DIM + 1),
  localparam int IDX_W  = $clog2(MAX_DIM),
  localparam int DEPTH  = MAX_DIM * MAX_DIM,
  localparam int ADDR_W = $clog2(DEPTH),
  localparam int B_W    = DIM_W + 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sok_pkg::dp_cmd_t                  cmd_i,
  output sok_pkg::dp_status_t               status_o,
  input  logic        [DIM_W-1:0]           n_rows_i,
  input  logic        [DIM_W-1:0]           n_cols_i,
  input  logic        [sok_pkg::COORD_W-1:0] wr_row_i,
  input  logic        [sok_pkg::COORD_W-1:0] wr_col_i,
  input  logic signed [sok_pkg::DATA_W-1:0] wr_value_i,
  input  logic        [sok_pkg::POS_W-1:0]  position_i,
  output logic                              rsp_valid_o,
  input  logic                              rsp_ready_i,
  output logic                              rsp_found_o,
  output logic signed [sok_pkg::DATA_W-1:0] rsp_element_o
);

  localparam logic signed [B_W-1:0] ONE = B_W'(1);

  logic        [sok_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic        [sok_pkg::DATA_W-1:0] rdata_q;
  logic signed [B_W-1:0]             top_q, top_d, bot_q, bot_d;
  logic signed [B_W-1:0]             lo_q, lo_d, hi_q, hi_d;
  logic        [sok_pkg::POS_W-1:0]  kk_q, kk_d;
  sok_pkg::side_e                    side_q, side_d;
  logic                              found_q;
  logic                              out_valid_q;
  logic                              out_found_q;
  logic        [sok_pkg::DATA_W-1:0] out_elem_q;

  logic signed [B_W-1:0]             len_s, off_s, row_s, col_s;
  logic        [sok_pkg::POS_W-1:0]  len_u;
  logic                              active, len_pos, hit, miss;
  logic        [IDX_W-1:0]           row_idx, col_idx;
  logic        [ADDR_W-1:0]          rd_addr, wr_addr;
  logic                              wr_ok;

  // one spiral side per step
  always_comb begin
    active = 1'b1;
    len_s  = '0;
    row_s  = '0;
    col_s  = '0;
    miss   = 1'b0;
    top_d  = top_q;
    bot_d  = bot_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    side_d = side_q;
    off_s  = signed'(B_W'(kk_q - sok_pkg::POS_W'(1)));
    unique case (side_q)
      sok_pkg::SIDE_TOP: begin
        active = (top_q <= bot_q) && (lo_q <= hi_q);
        miss   = !active || (kk_q == '0);
        len_s  = hi_q - lo_q + ONE;
        row_s  = top_q;
        col_s  = lo_q + off_s;
        top_d  = top_q + ONE;
        side_d = sok_pkg::SIDE_RIGHT;
      end
      sok_pkg::SIDE_RIGHT: begin
        len_s  = bot_q - top_q + ONE;
        row_s  = top_q + off_s;
        col_s  = hi_q;
        hi_d   = hi_q - ONE;
        side_d = sok_pkg::SIDE_BOTTOM;
      end
      sok_pkg::SIDE_BOTTOM: begin
        active = (bot_q >= top_q);
        len_s  = hi_q - lo_q + ONE;
        row_s  = bot_q;
        col_s  = hi_q - off_s;
        if (active) begin
          bot_d = bot_q - ONE;
        end
        side_d = sok_pkg::SIDE_LEFT;
      end
      sok_pkg::SIDE_LEFT: begin
        active = (lo_q <= hi_q);
        len_s  = bot_q - top_q + ONE;
        row_s  = bot_q - off_s;
        col_s  = lo_q;
        if (active) begin
          lo_d = lo_q + ONE;
        end
        side_d = sok_pkg::SIDE_TOP;
      end
      default: begin
        active = 1'b0;
      end
    endcase
    len_pos = active && (len_s > '0);
    len_u   = sok_pkg::POS_W'($unsigned(len_s));
    hit     = len_pos && (kk_q <= len_u) && !miss;
    kk_d    = (len_pos && !hit) ? (kk_q - len_u) : kk_q;
  end

  assign row_idx = row_s[IDX_W-1:0];
  assign col_idx = col_s[IDX_W-1:0];
  assign rd_addr = ADDR_W'(ADDR_W'(row_idx) * ADDR_W'(MAX_DIM)) + ADDR_W'(col_idx);
  assign wr_ok   = (32'(wr_row_i) < MAX_DIM) && (32'(wr_col_i) < MAX_DIM);
  assign wr_addr = ADDR_W'(32'(wr_row_i) * MAX_DIM + 32'(wr_col_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) begin
      mem_q[wr_addr] <= wr_value_i;
    end
    if (cmd_i.step && hit) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      top_q  <= '0;
      lo_q   <= '0;
      bot_q  <= signed'(B_W'(n_rows_i)) - ONE;
      hi_q   <= signed'(B_W'(n_cols_i)) - ONE;
      kk_q   <= position_i;
      side_q <= sok_pkg::SIDE_TOP;
    end else if (cmd_i.step) begin
      top_q  <= top_d;
      lo_q   <= lo_d;
      bot_q  <= bot_d;
      hi_q   <= hi_d;
      kk_q   <= kk_d;
      side_q <= side_d;
    end
    if (cmd_i.step && (hit || miss)) begin
      found_q <= hit;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_found_q <= found_q;
      out_elem_q  <= found_q ? rdata_q : '0;
    end
  end

  assign status_o.hit      = hit;
  assign status_o.miss     = miss;
  assign status_o.out_free = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o   = out_valid_q;
  assign rsp_found_o   = out_found_q;
  assign rsp_element_o = signed'(out_elem_q);

endmodule

@@ rtl/sok_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sok_checker
// Port-level checks on the request and result channels of the core.
// ----------------------------------------------------------------------------
module sok_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              req_valid_i,
  input logic                              req_ready_i,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic                              rsp_found_i,
  input logic signed [sok_pkg::DATA_W-1:0] rsp_element_i
);

  // stalled result stays
  a_rsp_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  a_rsp_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_found_i) && $stable(rsp_element_i))
    else $error("result changed while stalled");

  // miss carries zero element
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_found_i |-> rsp_element_i == '0)
    else $error("not-found result with nonzero element");

  // a result never appears right after a request is taken
  a_no_instant_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> !$past(req_valid_i && req_ready_i))
    else $error("result raised in the cycle after a request");

endmodule

bind spiral_order_kth_element_core sok_checker u_sok_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_found_i   (rsp_o.found),
  .rsp_element_i (rsp_o.element)
);
